FILE: rtl/multichannel_pcm_sample_mixer_defines.svh
// Assertion macros shared by the sample mixer RTL.
`ifndef MULTICHANNEL_PCM_SAMPLE_MIXER_DEFINES_SVH
`define MULTICHANNEL_PCM_SAMPLE_MIXER_DEFINES_SVH

`ifndef SYNTH
// Check a property at every rising clock edge outside reset.
`define MPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Check that one condition is followed by another in the next cycle.
`define MPM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define MPM_ASSERT(lbl, prop, msg)
`define MPM_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: rtl/mpm_pkg.sv
// Types, codes and constants of the PCM sample mixer.
package mpm_pkg;

  // Item kinds carried in tuser of the input item.
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_MIX   = 2'd2
  } action_e;

  // Mix sequencer, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_HOLD  = 4'b1000
  } mix_state_e;

  localparam int unsigned GAIN_MUL   = 255;
  localparam int unsigned GAIN_SHIFT = 8;

  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned MASK_W     = 4;

  // Channel gain from start volume: (255 * volume) >> 8.
  function automatic logic [7:0] gain_of(input logic [7:0] vol);
    logic [15:0] prod;
    prod = 16'(GAIN_MUL * 32'(vol));
    return 8'(prod >> GAIN_SHIFT);
  endfunction

endpackage

FILE: rtl/mpm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mpm_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 8192,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/multichannel_pcm_sample_mixer.sv
// Multichannel PCM sample mixer: top level with sample memory and mix sequencer.
// Usage:
//   Input stream (s_axis_*): one item per handshake, the action in tuser and
//   the other fields in tdata. Action write stores one signed 8-bit sample in
//   a channel's sample memory; action start sets a channel's play length
//   (saturated to SAMPLE_DEPTH) and gain and rewinds it; action mix produces
//   one output item; action 3 is dropped.
//   Output stream (m_axis_*): one item per mix item, carrying the 8-bit mix
//   shifted left by eight on both left and right, plus the active mask of the
//   four low channels after the tick.
// Sequence:
//   Write and start items leave the input ready. A mix item walks the channels
//   one per cycle through the single read port of the sample memory, drains
//   the last product, then hands the result to the output register: the input
//   is busy from the accepting edge until the hold state hands the result on,
//   so a new mix item is not taken before the last one is through. The result
//   turns valid in the output register after the scan, drain and hold states.
// Reset clears all channels to inactive with zero length, position and gain;
// sample memory is not cleared and must be written before it is played.
// A stalled receiver holds the result in the output register; further items
// are still taken, but the next mix then holds the input until it frees.
`include "multichannel_pcm_sample_mixer_defines.svh"

module multichannel_pcm_sample_mixer
  import mpm_pkg::*;
#(
  parameter int unsigned CHANNELS     = 4,
  parameter int unsigned SAMPLE_DEPTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // [1:0] action
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  // [1:0] channel, [12:2] address, [20:13] sample_value, [32:21] length,
  // [40:33] volume, [47:41] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] left_sample, [31:16] right_sample, [35:32] active_mask, [39:36] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready
);

  localparam int unsigned IdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PosW  = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned RamD  = CHANNELS * SAMPLE_DEPTH;
  localparam int unsigned RamAW = (RamD > 1) ? $clog2(RamD) : 1;

  // Input item fields.
  action_e           in_action;
  logic [1:0]        in_channel;
  logic [10:0]       in_address;
  logic signed [7:0] in_sample;
  logic [11:0]       in_length;
  logic [7:0]        in_volume;

  assign in_action  = action_e'(s_axis_tuser);
  assign in_channel = s_axis_tdata[1:0];
  assign in_address = s_axis_tdata[12:2];
  assign in_sample  = s_axis_tdata[20:13];
  assign in_length  = s_axis_tdata[32:21];
  assign in_volume  = s_axis_tdata[40:33];

  // Per-channel play state.
  logic [PosW-1:0] pos_q  [CHANNELS];
  logic [PosW-1:0] len_q  [CHANNELS];
  logic [7:0]      gain_q [CHANNELS];
  logic [CHANNELS-1:0] act_q;

  mix_state_e state_q, state_d;
  logic [IdxW-1:0] idx_q;
  logic [7:0]      mix_q, mix_d;
  logic [MASK_W-1:0] mask_q;

  // Product stage for the channel read in the previous cycle.
  logic       s2_rd_q;
  logic [7:0] s2_gain_q;

  // Result staged for the output register.
  logic [7:0]        res_mix_q;
  logic [MASK_W-1:0] res_mask_q;
  logic              out_vld_q;
  logic [7:0]        out_mix_q;
  logic [MASK_W-1:0] out_mask_q;

  logic in_acc, out_free, out_load;
  logic ch_ok, addr_ok;
  logic [IdxW-1:0] in_idx;
  logic [PosW-1:0] start_len;

  logic [PosW-1:0] cur_pos, cur_len, pos_nx;
  logic            cur_act, hit, act_nx, last_idx;

  logic             ram_wr_en, ram_rd_en;
  logic [RamAW-1:0] ram_wr_addr, ram_rd_addr;
  logic [7:0]       ram_rd_data;
  logic signed [16:0] prod;
  logic [7:0]       addend;
  logic [CHANNELS-1:0] pos_below_len;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign ch_ok   = 32'(in_channel) < 32'(CHANNELS);
  assign addr_ok = 32'(in_address) < 32'(SAMPLE_DEPTH);
  assign in_idx  = IdxW'(in_channel);
  // Saturate the start length to the memory depth.
  assign start_len = (32'(in_length) > 32'(SAMPLE_DEPTH)) ? PosW'(SAMPLE_DEPTH)
                                                          : PosW'(in_length);

  // Scan stage: look at one channel, issue its sample read, advance it.
  assign cur_pos  = pos_q[idx_q];
  assign cur_len  = len_q[idx_q];
  assign cur_act  = act_q[idx_q];
  assign hit      = (state_q == ST_SCAN) && cur_act && (cur_pos < cur_len);
  assign pos_nx   = cur_pos + PosW'(hit);
  assign act_nx   = cur_act && (pos_nx < cur_len);
  assign last_idx = (idx_q == IdxW'(CHANNELS - 1));

  // Sample memory, one region of SAMPLE_DEPTH entries per channel.
  assign ram_wr_en   = in_acc && (in_action == ACT_WRITE) && ch_ok && addr_ok;
  assign ram_wr_addr = RamAW'(in_idx) * RamAW'(SAMPLE_DEPTH) + RamAW'(in_address);
  assign ram_rd_en   = hit;
  assign ram_rd_addr = RamAW'(idx_q) * RamAW'(SAMPLE_DEPTH) + RamAW'(cur_pos);

  mpm_ram #(
    .WIDTH (8),
    .DEPTH (RamD)
  ) u_sample_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (in_sample),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // Product stage: (sample * gain) >>> 8, wrapped into the 8-bit mix.
  assign prod   = $signed(ram_rd_data) * $signed({1'b0, s2_gain_q});
  assign addend = s2_rd_q ? prod[15:8] : 8'd0;
  assign mix_d  = mix_q + addend;

  assign out_free = !out_vld_q || m_axis_tready;
  assign out_load = (state_q == ST_HOLD) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_action == ACT_MIX)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_idx) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_HOLD;
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      act_q     <= '0;
      s2_rd_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        pos_q[c]  <= '0;
        len_q[c]  <= '0;
        gain_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      s2_rd_q <= hit;

      // Start: load length and gain, rewind, activate on nonzero length.
      if (in_acc && (in_action == ACT_START) && ch_ok) begin
        pos_q[in_idx]  <= '0;
        len_q[in_idx]  <= start_len;
        gain_q[in_idx] <= gain_of(in_volume);
        act_q[in_idx]  <= (start_len != '0);
      end

      if (state_q == ST_SCAN) begin
        pos_q[idx_q] <= pos_nx;
        act_q[idx_q] <= act_nx;
        idx_q        <= last_idx ? '0 : idx_q + 1'b1;
      end

      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    s2_gain_q <= gain_q[idx_q];
    if (in_acc && (in_action == ACT_MIX)) begin
      mix_q  <= '0;
      mask_q <= '0;
    end else begin
      mix_q <= mix_d;
      if ((state_q == ST_SCAN) && (32'(idx_q) < 32'(MASK_W))) begin
        mask_q[2'(idx_q)] <= act_nx;
      end
    end
    if (state_q == ST_DRAIN) begin
      res_mix_q  <= mix_d;
      res_mask_q <= mask_q;
    end
    if (out_load) begin
      out_mix_q  <= res_mix_q;
      out_mask_q <= res_mask_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, out_mask_q, out_mix_q, 8'd0, out_mix_q, 8'd0};

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      pos_below_len[c] = pos_q[c] < len_q[c];
    end
  end

  `MPM_ASSERT(a_rd_only_in_scan, ram_rd_en |-> (state_q == ST_SCAN),
              "sample read issued outside the channel scan")
  `MPM_ASSERT(a_active_has_samples,
              (state_q == ST_IDLE) |-> ((act_q & ~pos_below_len) == '0),
              "active channel has no samples left")
  `MPM_ASSERT_NEXT(a_drain_to_hold, state_q == ST_DRAIN, state_q == ST_HOLD,
                   "mix result not staged after drain")

endmodule

FILE: verif/mpm_tb_pkg.sv
// Item layouts of the sample mixer streams as the testbench sees them.
`timescale 1ns / 100ps

package mpm_tb_pkg;
  import mpm_pkg::*;

  // The block drops this action code without a result.
  localparam logic [1:0] ACT_NOP = 2'd3;

  // Input item tdata, lowest field last; the action travels in tuser.
  typedef struct packed {
    logic [6:0]        pad;
    logic [7:0]        volume;
    logic [11:0]       length;
    logic signed [7:0] sample_value;
    logic [10:0]       address;
    logic [1:0]        channel;
  } mixer_cmd_t;

  // Output item, lowest field last.
  typedef struct packed {
    logic [3:0]         pad;
    logic [MASK_W-1:0]  active_mask;
    logic signed [15:0] right_sample;
    logic signed [15:0] left_sample;
  } mixer_out_t;

endpackage

FILE: verif/multichannel_pcm_sample_mixer_checker.sv
// Checker for the sample mixer: tracks accepted items, predicts mixes, compares outputs.
`timescale 1ns / 100ps

module multichannel_pcm_sample_mixer_checker
  import mpm_pkg::*;
  import mpm_tb_pkg::*;
#(
  parameter int unsigned CHANNELS     = 4,
  parameter int unsigned SAMPLE_DEPTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_USER_W-1:0]  s_tuser_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam int unsigned VOL_SCALE = 255;
  localparam int unsigned GAIN_FRAC = 8;

  logic signed [7:0] pcm_mem [CHANNELS][SAMPLE_DEPTH];
  logic [11:0]       play_ptr [CHANNELS];
  logic [11:0]       play_len [CHANNELS];
  logic [7:0]        gain_q   [CHANNELS];
  logic              playing  [CHANNELS];

  mixer_out_t  mix_q [$];
  mixer_cmd_t  cmd_in;
  logic [1:0]  act_in;
  mixer_out_t  got_out;
  mixer_out_t  want_out;
  int unsigned fails = 0;

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // One mix tick: sum every playing channel into a wrapping 8-bit accumulator.
  function automatic mixer_out_t mix_tick();
    mixer_out_t r;
    logic [7:0] acc;
    int         prod;
    r   = '0;
    acc = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (playing[c]) begin
        if (play_ptr[c] < play_len[c] && play_ptr[c] < SAMPLE_DEPTH) begin
          prod = int'(pcm_mem[c][play_ptr[c]]) * int'(gain_q[c]);
          acc  = acc + 8'(prod >>> GAIN_FRAC);
          play_ptr[c] = play_ptr[c] + 12'd1;
        end
        if (play_ptr[c] >= play_len[c]) playing[c] = 1'b0;
        if (playing[c] && c < MASK_W) r.active_mask[c] = 1'b1;
      end
    end
    r.left_sample  = {acc, 8'h00};
    r.right_sample = {acc, 8'h00};
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        play_ptr[c] = '0;
        play_len[c] = '0;
        gain_q[c]   = '0;
        playing[c]  = 1'b0;
      end
      mix_q.delete();
    end else begin
      // Results leave in order, so the oldest prediction is the one to match.
      if (m_tvalid_i && m_tready_i) begin
        got_out = mixer_out_t'(m_tdata_i);
        if (mix_q.size() == 0) begin
          fails++;
          $display("%0t: output item with no mix pending, expected none, %s %0d %0d %h",
                   $time, "got left, right, mask", got_out.left_sample,
                   got_out.right_sample, got_out.active_mask);
        end else begin
          want_out = mix_q.pop_front();
          compare_field("left_sample", want_out.left_sample, got_out.left_sample);
          compare_field("right_sample", want_out.right_sample, got_out.right_sample);
          compare_field("active_mask", want_out.active_mask, got_out.active_mask);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        cmd_in = mixer_cmd_t'(s_tdata_i);
        act_in = s_tuser_i;
        case (act_in)
          ACT_WRITE: begin
            if (cmd_in.channel < CHANNELS && cmd_in.address < SAMPLE_DEPTH)
              pcm_mem[cmd_in.channel][cmd_in.address] = cmd_in.sample_value;
          end
          ACT_START: begin
            if (cmd_in.channel < CHANNELS) begin
              play_len[cmd_in.channel] = (cmd_in.length > SAMPLE_DEPTH) ?
                                         12'(SAMPLE_DEPTH) : cmd_in.length;
              play_ptr[cmd_in.channel] = '0;
              gain_q[cmd_in.channel]   = 8'((VOL_SCALE * int'(cmd_in.volume)) >> GAIN_FRAC);
              playing[cmd_in.channel]  = (cmd_in.length != 0);
            end
          end
          ACT_MIX: mix_q.push_back(mix_tick());
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= mix_q.size();
  end

endmodule

FILE: verif/multichannel_pcm_sample_mixer_tb.sv
// Testbench top for the sample mixer: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module multichannel_pcm_sample_mixer_tb
  import mpm_pkg::*;
  import mpm_tb_pkg::*;
();

  localparam int unsigned CHANNELS       = 4;
  localparam int unsigned SAMPLE_DEPTH   = 2048;
  localparam int unsigned RANDOM_ITEMS   = 1600;
  localparam int unsigned STEADY_FROM    = 700;
  localparam int unsigned STEADY_TO      = 1000;
  localparam int unsigned DRAIN_POINT    = 400;
  localparam int unsigned TAIL_CYCLES    = 4 * (CHANNELS + 3);
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;

  int unsigned fail_count;
  int unsigned pending_results;

  // Stimulus-side view of the channels: just enough to never play an
  // entry of the sample memory that has not been written.
  bit          sample_seen [CHANNELS][SAMPLE_DEPTH];
  bit [11:0]   sh_pos [CHANNELS];
  bit [11:0]   sh_len [CHANNELS];
  bit          sh_act [CHANNELS];

  bit          steady = 1'b0;
  int unsigned issued = 0;
  int unsigned n_writes = 0;
  int unsigned n_starts = 0;
  int unsigned n_mixes = 0;
  int unsigned n_dropped = 0;
  int unsigned quiet_cycles = 0;

  multichannel_pcm_sample_mixer #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  multichannel_pcm_sample_mixer_checker #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tuser_i   (s_axis_tuser),
    .s_tdata_i   (s_axis_tdata),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .fail_count_o(fail_count),
    .pending_o   (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: stall about a quarter of the cycles, never during the steady stretch.
  always @(posedge clk_i) begin
    if (steady) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(99) >= 25);
  end

  // Watchdog: end the run once nothing has moved on either stream for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // Fill every field at random; callers then set the ones their action uses,
  // so the unused fields carry noise the block must ignore.
  function automatic mixer_cmd_t random_cmd();
    mixer_cmd_t cmd;
    cmd              = '0;
    cmd.channel      = 2'($urandom);
    cmd.address      = 11'($urandom);
    cmd.sample_value = 8'($urandom);
    cmd.length       = 12'($urandom);
    cmd.volume       = 8'($urandom);
    return cmd;
  endfunction

  // Offer one item, hold it until taken, then mirror its effect on the channels.
  task automatic push_item(input logic [1:0] act, input mixer_cmd_t cmd);
    while (!steady && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tuser  <= act;
    s_axis_tdata  <= cmd;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    case (act)
      ACT_WRITE: begin
        sample_seen[cmd.channel][cmd.address] = 1'b1;
        n_writes++;
      end
      ACT_START: begin
        sh_len[cmd.channel] = (cmd.length > SAMPLE_DEPTH) ? 12'(SAMPLE_DEPTH) : cmd.length;
        sh_pos[cmd.channel] = '0;
        sh_act[cmd.channel] = (cmd.length != 0);
        n_starts++;
      end
      ACT_MIX: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (sh_act[c]) begin
            sh_pos[c] = sh_pos[c] + 12'd1;
            if (sh_pos[c] >= sh_len[c]) sh_act[c] = 1'b0;
          end
        end
        n_mixes++;
      end
      default: n_dropped++;
    endcase
    if (act != ACT_NOP) issued++;
  endtask

  task automatic write_sample(input int ch, input int addr, input logic [7:0] val);
    mixer_cmd_t cmd;
    cmd              = random_cmd();
    cmd.channel      = 2'(ch);
    cmd.address      = 11'(addr);
    cmd.sample_value = val;
    push_item(ACT_WRITE, cmd);
  endtask

  task automatic start_channel(input int ch, input int len, input int vol);
    mixer_cmd_t cmd;
    cmd         = random_cmd();
    cmd.channel = 2'(ch);
    cmd.length  = 12'(len);
    cmd.volume  = 8'(vol);
    push_item(ACT_START, cmd);
  endtask

  // Before a tick, fill any entry that a playing channel is about to read.
  task automatic mix_once();
    mixer_cmd_t cmd;
    for (int c = 0; c < CHANNELS; c++) begin
      if (sh_act[c] && !sample_seen[c][sh_pos[c][10:0]])
        write_sample(c, sh_pos[c], 8'($urandom));
    end
    cmd = random_cmd();
    push_item(ACT_MIX, cmd);
  endtask

  initial begin
    mixer_cmd_t  cmd;
    int unsigned base;
    int unsigned pick;
    int unsigned len;
    int unsigned addr;
    bit          drained;

    drained = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: sample and volume extremes, gain of zero, zero length,
    // a dropped action, length saturation, restart, and a wrapping sum.
    write_sample(0, 0, 8'sh80);
    write_sample(0, 1, 8'sh7f);
    write_sample(0, 2047, 8'sh7f);
    write_sample(3, 0, 8'shff);
    start_channel(0, 2, 255);
    start_channel(3, 1, 0);
    start_channel(1, 0, 128);
    mix_once();
    mix_once();
    mix_once();
    cmd     = '1;
    cmd.pad = '0;
    push_item(ACT_NOP, cmd);
    start_channel(2, 4095, 255);
    mix_once();
    mix_once();
    start_channel(2, 3, 200);
    mix_once();
    for (int c = 0; c < CHANNELS; c++) write_sample(c, 0, 8'sh7f);
    for (int c = 0; c < CHANNELS; c++) start_channel(c, 1, 255);
    mix_once();

    // Random part: mostly writes near the start of memory, starts with
    // short lengths and mixes, plus some dropped items.
    base = issued;
    while (issued - base < RANDOM_ITEMS) begin
      steady = (issued - base >= STEADY_FROM) && (issued - base < STEADY_TO);
      if (!drained && issued - base >= DRAIN_POINT) begin
        // Hold the input until every pending mix has come out.
        drained = 1'b1;
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending_results != 0) @(posedge clk_i);
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        addr = ($urandom_range(9) == 0) ? $urandom_range(SAMPLE_DEPTH - 1) : $urandom_range(63);
        write_sample($urandom_range(CHANNELS - 1), addr, 8'($urandom));
      end else if (pick < 50) begin
        case ($urandom_range(9))
          0:       len = 0;
          1:       len = $urandom_range(4095, SAMPLE_DEPTH + 1);
          2:       len = $urandom_range(SAMPLE_DEPTH, 49);
          default: len = $urandom_range(48, 1);
        endcase
        start_channel($urandom_range(CHANNELS - 1), len, $urandom_range(255));
      end else if (pick < 95) begin
        mix_once();
      end else begin
        cmd = random_cmd();
        push_item(ACT_NOP, cmd);
      end
    end
    steady = 1'b0;

    // Drop valid, let the last mixes come out, then give the block time
    // to show any stray output.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d sample writes, %0d channel starts, %0d mix ticks, %0d dropped items",
             n_writes, n_starts, n_mixes, n_dropped);
    $display("random stalls on both streams, one stall-free stretch and one full drain");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mpm_pkg.sv
rtl/mpm_ram.sv
rtl/multichannel_pcm_sample_mixer.sv
verif/mpm_tb_pkg.sv
verif/multichannel_pcm_sample_mixer_checker.sv
verif/multichannel_pcm_sample_mixer_tb.sv
